// ===== design/srd_pkg.sv =====
// Shared types for the signed restoring divider pipeline.
`default_nettype none

package srd_pkg;

    // Control that travels alongside each word through the step stages.
    typedef struct packed {
        logic valid;
        logic zero_div;
        logic signs_differ;
    } srd_ctrl_t;

endpackage

`default_nettype wire

// ===== design/srd_step.sv =====
// One registered step of signed restoring division over the AQ register.
`default_nettype none

module srd_step
    import srd_pkg::*;
#(
    parameter int REGISTER_WIDTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire srd_ctrl_t                       in_ctrl,
    input  wire logic [REGISTER_WIDTH-1:0]       in_aq,
    input  wire logic [REGISTER_WIDTH/2-1:0]     in_dvs,
    output logic                                 in_ready,
    output srd_ctrl_t                            out_ctrl,
    output logic [REGISTER_WIDTH-1:0]            out_aq,
    output logic [REGISTER_WIDTH/2-1:0]          out_dvs,
    input  wire logic                            out_ready
);

    localparam int HalfWidth = REGISTER_WIDTH / 2;

    srd_ctrl_t                   ctrl_reg;
    logic [REGISTER_WIDTH-1:0]   aq_reg;
    logic [HalfWidth-1:0]        dvs_reg;
    logic [REGISTER_WIDTH-1:0]   aq_next;
    logic [REGISTER_WIDTH-1:0]   shifted;
    logic [REGISTER_WIDTH-1:0]   m_full;
    logic [REGISTER_WIDTH-1:0]   trial;
    logic                        keep;

    // Shift AQ left, then subtract M when the signs agree and add it otherwise.
    always_comb begin
        shifted = {in_aq[REGISTER_WIDTH-2:0], 1'b0};
        m_full  = {in_dvs, {HalfWidth{1'b0}}};
        if (shifted[REGISTER_WIDTH-1] == in_dvs[HalfWidth-1]) begin
            trial = shifted - m_full;
        end else begin
            trial = shifted + m_full;
        end
        // Keep the trial value when the sign held or the whole word became zero.
        keep = (shifted[REGISTER_WIDTH-1] == trial[REGISTER_WIDTH-1]) || (trial == '0);
        if (keep) begin
            aq_next = {trial[REGISTER_WIDTH-1:1], 1'b1};
        end else begin
            aq_next = shifted;
        end
    end

    // The stage may load whenever it is empty or its word moves on.
    assign in_ready = !ctrl_reg.valid || out_ready;

    // Control is reset; the payload registers load with the word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (in_ready) begin
            ctrl_reg <= in_ctrl;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_ctrl.valid) begin
            aq_reg  <= aq_next;
            dvs_reg <= in_dvs;
        end
    end

    assign out_ctrl = ctrl_reg;
    assign out_aq   = aq_reg;
    assign out_dvs  = dvs_reg;

endmodule

`default_nettype wire

// ===== design/signed_restoring_divider.sv =====
// Pipelined signed restoring divider: REGISTER_WIDTH-bit dividend by half-width divisor.
//
// Usage: a dividend and divisor word enters on the s_ channel (s_valid/s_ready)
// and one result word leaves on the m_ channel (m_valid/m_ready) carrying the
// quotient, the remainder and a divide-by-zero flag. When the flag is set the
// quotient and remainder read as zero.
// A word passes through one register stage for each of the REGISTER_WIDTH/2
// restoring steps, then the output stage that applies the sign correction to
// the quotient.
// Throughput is one word per cycle; each stage holds one word, so a new word
// enters every cycle while the output is taken.
// Reset clears every valid bit, so the pipeline comes out of reset empty.
// When the receiver holds m_ready low, the words close up behind the output
// register and s_ready falls only once every stage is full; nothing is lost
// or repeated.
`default_nettype none

module signed_restoring_divider
    import srd_pkg::*;
#(
    parameter int REGISTER_WIDTH = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [REGISTER_WIDTH-1:0]   s_dividend,
    input  wire logic signed [REGISTER_WIDTH/2-1:0] s_divisor,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic signed [REGISTER_WIDTH/2-1:0]      m_quotient,
    output logic signed [REGISTER_WIDTH/2-1:0]      m_remainder,
    output logic                                    m_zero_divisor
);

    localparam int HalfWidth = REGISTER_WIDTH / 2;

    srd_ctrl_t                 stage_ctrl  [0:HalfWidth];
    logic [REGISTER_WIDTH-1:0] stage_aq    [0:HalfWidth];
    logic [HalfWidth-1:0]      stage_dvs   [0:HalfWidth];
    logic                      stage_ready [0:HalfWidth];

    logic                      m_valid_reg;
    logic [HalfWidth-1:0]      m_quotient_reg;
    logic [HalfWidth-1:0]      m_remainder_reg;
    logic                      m_zero_divisor_reg;
    logic [HalfWidth-1:0]      quotient_next;
    logic [HalfWidth-1:0]      remainder_next;
    logic [HalfWidth-1:0]      q_low;

    // Incoming word feeds the first step directly.
    always_comb begin
        stage_ctrl[0].valid        = s_valid;
        stage_ctrl[0].zero_div     = (s_divisor == '0);
        stage_ctrl[0].signs_differ = s_dividend[REGISTER_WIDTH-1] ^ s_divisor[HalfWidth-1];
        stage_aq[0]                = s_dividend;
        stage_dvs[0]               = s_divisor;
    end

    assign s_ready = stage_ready[0];

    // One register stage per restoring step.
    for (genvar i = 0; i < HalfWidth; i++) begin : g_step
        srd_step #(
            .REGISTER_WIDTH(REGISTER_WIDTH)
        ) u_step (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .in_ctrl  (stage_ctrl[i]),
            .in_aq    (stage_aq[i]),
            .in_dvs   (stage_dvs[i]),
            .in_ready (stage_ready[i]),
            .out_ctrl (stage_ctrl[i+1]),
            .out_aq   (stage_aq[i+1]),
            .out_dvs  (stage_dvs[i+1]),
            .out_ready(stage_ready[i+1])
        );
    end

    // Output stage: sign correction of the quotient and zero-divisor masking.
    assign stage_ready[HalfWidth] = !m_valid_reg || m_ready;

    always_comb begin
        q_low = stage_aq[HalfWidth][HalfWidth-1:0];
        if (stage_ctrl[HalfWidth].zero_div) begin
            quotient_next  = '0;
            remainder_next = '0;
        end else begin
            remainder_next = stage_aq[HalfWidth][REGISTER_WIDTH-1:HalfWidth];
            if (stage_ctrl[HalfWidth].signs_differ) begin
                quotient_next = '0 - q_low;
            end else begin
                quotient_next = q_low;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (stage_ready[HalfWidth]) begin
            m_valid_reg <= stage_ctrl[HalfWidth].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_ready[HalfWidth] && stage_ctrl[HalfWidth].valid) begin
            m_quotient_reg     <= quotient_next;
            m_remainder_reg    <= remainder_next;
            m_zero_divisor_reg <= stage_ctrl[HalfWidth].zero_div;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_quotient     = m_quotient_reg;
    assign m_remainder    = m_remainder_reg;
    assign m_zero_divisor = m_zero_divisor_reg;

    // A zero divisor always comes out with a cleared quotient and remainder.
    a_zero_div_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_divisor |-> m_quotient == '0 && m_remainder == '0)
        else $error("zero divisor word carries non-zero results");

    // Input back-pressure only arises when the first stage holds a word.
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stage_ctrl[1].valid)
        else $error("input stalled while first stage empty");

    // The pipeline is empty straight after reset.
    a_empty_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A word waiting in the output register is held until taken.
    a_output_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_quotient) && $stable(m_remainder))
        else $error("result word changed while stalled");

endmodule

`default_nettype wire
